### src/gyro_tilt_gesture_detector_defines.svh
// assertion macros for the gyro tilt gesture detector
// used by the top level only, needs clk and rst_n in scope
`ifndef GYRO_TILT_GESTURE_DETECTOR_DEFINES_SVH
`define GYRO_TILT_GESTURE_DETECTOR_DEFINES_SVH

// condition implies consequence in the same cycle
`define GTTG_ASSERT_SAME(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define GTTG_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

### src/gttg_pkg.sv
// shared types and constants for the gyro tilt gesture detector
// no dependencies; used by the lane, merge and top modules
package gttg_pkg;

  localparam int RATE_W  = 23;
  localparam int SUM_W   = 28;
  localparam int ANG_W   = 10;
  localparam int REM_W   = 9;
  localparam int THR_W   = 9;
  localparam int CODE_W  = 3;

  // exact floor(mag / 100000) for mag < 2**28 via reciprocal multiply
  localparam int RECIP_W = 29;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int SHIFT   = 45;
  localparam int Q_W     = PROD_W - SHIFT;
  localparam logic [RECIP_W-1:0] RECIP = 29'd351843721;

  localparam logic [Q_W-1:0] TURN1 = 12'd360;
  localparam logic [Q_W-1:0] TURN2 = 12'd720;
  localparam logic [Q_W-1:0] TURN3 = 12'd1080;

  localparam logic [THR_W-1:0] THR_RESET = 9'd15;

  // gesture codes
  localparam logic [CODE_W-1:0] GEST_X_POS = 3'd0;
  localparam logic [CODE_W-1:0] GEST_X_NEG = 3'd1;
  localparam logic [CODE_W-1:0] GEST_Y_POS = 3'd2;
  localparam logic [CODE_W-1:0] GEST_Y_NEG = 3'd3;
  localparam logic [CODE_W-1:0] GEST_Z_POS = 3'd4;
  localparam logic [CODE_W-1:0] GEST_Z_NEG = 3'd5;

  // pending tilt: code + 1, zero when idle
  localparam logic [CODE_W-1:0] PEND_IDLE   = 3'd0;
  localparam logic [CODE_W-1:0] PEND_UNUSED = 3'd7;

  typedef logic signed [ANG_W-1:0] angle_t;

  // lane pipeline controls from the top level
  typedef struct packed {
    logic acc;    // sample word accepted
    logic last;   // accepted word closes the window
    logic en_a;   // stage a may load
    logic en_b;   // stage b may load
    logic en_c;   // stage c may load
  } lane_ctl_t;

endpackage

### src/gttg_lane.sv
// one axis lane: window accumulator, reciprocal divide, remainder 360
// depends on gttg_pkg
module gttg_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gttg_pkg::lane_ctl_t                 ctl,
  input  logic signed [gttg_pkg::RATE_W-1:0]  rate,
  output gttg_pkg::angle_t                    angle
);

  logic signed [gttg_pkg::SUM_W-1:0]  sum_r;
  logic signed [gttg_pkg::SUM_W-1:0]  sum_nxt;
  logic        [gttg_pkg::SUM_W-1:0]  mag_a_r;
  logic                               neg_a_r;
  logic        [gttg_pkg::PROD_W-1:0] prod_b_r;
  logic                               neg_b_r;
  gttg_pkg::angle_t                   angle_c_r;
  logic        [gttg_pkg::Q_W-1:0]    quot;
  logic        [gttg_pkg::Q_W-1:0]    rem_q;
  logic        [gttg_pkg::REM_W-1:0]  rem;

  assign sum_nxt = sum_r + {{(gttg_pkg::SUM_W-gttg_pkg::RATE_W){rate[gttg_pkg::RATE_W-1]}},
                            rate};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.acc) begin
      sum_r <= ctl.last ? '0 : sum_nxt;
    end
  end

  // stage a: sign and magnitude of the closed window sum
  always_ff @(posedge clk) begin
    if (ctl.en_a) begin
      neg_a_r <= sum_nxt[gttg_pkg::SUM_W-1];
      mag_a_r <= sum_nxt[gttg_pkg::SUM_W-1] ? gttg_pkg::SUM_W'(-sum_nxt)
                                             : gttg_pkg::SUM_W'(sum_nxt);
    end
  end

  // stage b: multiply by the reciprocal of 100000
  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      neg_b_r  <= neg_a_r;
      prod_b_r <= gttg_pkg::PROD_W'(mag_a_r) * gttg_pkg::PROD_W'(gttg_pkg::RECIP);
    end
  end

  // stage c: quotient is below 4 turns, so one of three subtractions
  assign quot = prod_b_r[gttg_pkg::PROD_W-1:gttg_pkg::SHIFT];

  always_comb begin
    if (quot >= gttg_pkg::TURN3) begin
      rem_q = quot - gttg_pkg::TURN3;
    end else if (quot >= gttg_pkg::TURN2) begin
      rem_q = quot - gttg_pkg::TURN2;
    end else if (quot >= gttg_pkg::TURN1) begin
      rem_q = quot - gttg_pkg::TURN1;
    end else begin
      rem_q = quot;
    end
  end

  assign rem = rem_q[gttg_pkg::REM_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.en_c) begin
      angle_c_r <= neg_b_r ? -$signed({1'b0, rem}) : $signed({1'b0, rem});
    end
  end

  assign angle = angle_c_r;

endmodule

### src/gttg_merge.sv
// merge stage: two-phase tilt and return machine over the three lane angles
// holds the output register; depends on gttg_pkg
module gttg_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gttg_pkg::angle_t              ang_x,
  input  gttg_pkg::angle_t              ang_y,
  input  gttg_pkg::angle_t              ang_z,
  input  logic [gttg_pkg::THR_W-1:0]    thr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gttg_pkg::angle_t              out_ang_x,
  output gttg_pkg::angle_t              out_ang_y,
  output gttg_pkg::angle_t              out_ang_z,
  output logic                          out_gest_valid,
  output logic [gttg_pkg::CODE_W-1:0]   out_gest_code
);

  localparam int CMP_W = gttg_pkg::ANG_W + 1;

  logic                          valid_r;
  logic [gttg_pkg::CODE_W-1:0]   pend_r;
  logic [gttg_pkg::CODE_W-1:0]   pend_nxt;
  gttg_pkg::angle_t              ax_r, ay_r, az_r;
  logic                          gv_r, gv_nxt;
  logic [gttg_pkg::CODE_W-1:0]   gc_r, gc_nxt;
  logic [gttg_pkg::CODE_W-1:0]   code_p;
  logic signed [CMP_W-1:0]       thr_s;
  logic [2:0]                    below;
  logic [2:0]                    above;
  logic                          back;
  logic                          take;

  assign thr_s = $signed({2'b00, thr});

  assign below[0] = CMP_W'(ang_x) < -thr_s;
  assign below[1] = CMP_W'(ang_y) < -thr_s;
  assign below[2] = CMP_W'(ang_z) < -thr_s;
  assign above[0] = CMP_W'(ang_x) > thr_s;
  assign above[1] = CMP_W'(ang_y) > thr_s;
  assign above[2] = CMP_W'(ang_z) > thr_s;

  assign code_p = pend_r - 3'd1;

  always_comb begin
    case (code_p)
      gttg_pkg::GEST_X_POS: back = below[0];
      gttg_pkg::GEST_X_NEG: back = above[0];
      gttg_pkg::GEST_Y_POS: back = below[1];
      gttg_pkg::GEST_Y_NEG: back = above[1];
      gttg_pkg::GEST_Z_POS: back = below[2];
      gttg_pkg::GEST_Z_NEG: back = above[2];
      default:              back = 1'b0;
    endcase
  end

  always_comb begin
    gv_nxt   = 1'b0;
    gc_nxt   = gttg_pkg::GEST_X_POS;
    pend_nxt = gttg_pkg::PEND_IDLE;
    if (pend_r inside {gttg_pkg::PEND_IDLE, gttg_pkg::PEND_UNUSED}) begin
      // record a tilt, x first, then y, then z
      if (below[0]) begin
        pend_nxt = gttg_pkg::GEST_X_NEG + 3'd1;
      end else if (above[0]) begin
        pend_nxt = gttg_pkg::GEST_X_POS + 3'd1;
      end else if (below[1]) begin
        pend_nxt = gttg_pkg::GEST_Y_NEG + 3'd1;
      end else if (above[1]) begin
        pend_nxt = gttg_pkg::GEST_Y_POS + 3'd1;
      end else if (below[2]) begin
        pend_nxt = gttg_pkg::GEST_Z_NEG + 3'd1;
      end else if (above[2]) begin
        pend_nxt = gttg_pkg::GEST_Z_POS + 3'd1;
      end
    end else if (back) begin
      gv_nxt = 1'b1;
      gc_nxt = code_p;
    end
  end

  assign in_ready = !valid_r || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= gttg_pkg::PEND_IDLE;
    end else begin
      if (take) begin
        valid_r <= 1'b1;
        pend_r  <= pend_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ax_r <= ang_x;
      ay_r <= ang_y;
      az_r <= ang_z;
      gv_r <= gv_nxt;
      gc_r <= gc_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_ang_x      = ax_r;
  assign out_ang_y      = ay_r;
  assign out_ang_z      = az_r;
  assign out_gest_valid = gv_r;
  assign out_gest_code  = gc_r;

endmodule

### src/gyro_tilt_gesture_detector.sv
// a window's closing word reaches the output through registered lane stages a, b, c and the output register
// throughput: one sample word per cycle; a closing word needs room in lane stage a,
// other words are taken even while a result waits at the output
// window sums feed a 28 x 29 reciprocal multiply in each of three axis lanes
// reset (synchronous, rst_n low): sums, sample count and pending tilt cleared,
// threshold back to 15 degrees, no result pending
module gyro_tilt_gesture_detector #(
  parameter int WINDOW_SAMPLES = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // rate_x [22:0], rate_y [45:23], rate_z [68:46], zero fill [71:69]
  input  logic [71:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // angle_x [9:0], angle_y [19:10], angle_z [29:20], gesture_valid [30],
  // gesture_code [33:31], zero fill [39:34]
  output logic [39:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tilt_threshold_deg [8:0]
  input  logic [8:0]  cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);

  `include "gyro_tilt_gesture_detector_defines.svh"

  localparam int CNT_W = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_SAMPLES - 1);

  logic [CNT_W-1:0]              cnt_r;
  logic [gttg_pkg::THR_W-1:0]    thr_r;
  logic                          va_r, vb_r, vc_r;
  logic                          last;
  logic                          merge_ready;
  gttg_pkg::lane_ctl_t           ctl;
  gttg_pkg::angle_t              ang_x, ang_y, ang_z;
  gttg_pkg::angle_t              o_ax, o_ay, o_az;
  logic                          o_gv;
  logic [gttg_pkg::CODE_W-1:0]   o_gc;

  assign last     = cnt_r == CNT_LAST;
  assign ctl.en_c = !vc_r || merge_ready;
  assign ctl.en_b = !vb_r || ctl.en_c;
  assign ctl.en_a = !va_r || ctl.en_b;
  assign ctl.last = last;

  // only a closing word pushes into the lane pipeline
  assign in_tready = !last || ctl.en_a;
  assign ctl.acc   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      thr_r <= gttg_pkg::THR_RESET;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      vc_r  <= 1'b0;
    end else begin
      if (ctl.acc) begin
        cnt_r <= last ? '0 : cnt_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (ctl.en_a) begin
        va_r <= ctl.acc && last;
      end
      if (ctl.en_b) begin
        vb_r <= va_r;
      end
      if (ctl.en_c) begin
        vc_r <= vb_r;
      end
    end
  end

  gttg_lane u_lane_x (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .rate  (in_tdata[22:0]),
    .angle (ang_x)
  );

  gttg_lane u_lane_y (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .rate  (in_tdata[45:23]),
    .angle (ang_y)
  );

  gttg_lane u_lane_z (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .rate  (in_tdata[68:46]),
    .angle (ang_z)
  );

  gttg_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (vc_r),
    .in_ready       (merge_ready),
    .ang_x          (ang_x),
    .ang_y          (ang_y),
    .ang_z          (ang_z),
    .thr            (thr_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_ang_x      (o_ax),
    .out_ang_y      (o_ay),
    .out_ang_z      (o_az),
    .out_gest_valid (o_gv),
    .out_gest_code  (o_gc)
  );

  assign out_tdata = {6'd0, o_gc, o_gv, o_az, o_ay, o_ax};

  `GTTG_ASSERT_NEXT(a_close_enters_pipe, ctl.acc && last, va_r,
                    "closing word did not enter lane stage a")
  `GTTG_ASSERT_NEXT(a_stage_c_holds, vc_r && !ctl.en_c, vc_r,
                    "stage c dropped a window while the merge stage was full")
  `GTTG_ASSERT_SAME(a_code_clean, out_tvalid && !out_tdata[30], out_tdata[33:31] == 3'd0,
                    "gesture code set without a gesture")

endmodule
